>>> hw/rtl/pibt_pkg.sv
package pibt_pkg;

   // request opcodes
   localparam logic [2:0] OP_CFG_RD = 3'd0;
   localparam logic [2:0] OP_CFG_WR = 3'd1;
   localparam logic [2:0] OP_IO_RD  = 3'd2;
   localparam logic [2:0] OP_IO_WR  = 3'd3;
   localparam logic [2:0] OP_TICK   = 3'd4;

   // CSR register indexes
   localparam logic CSR_REVISION = 1'b0;
   localparam logic CSR_CLK_SEL  = 1'b1;

   // configuration space
   localparam int CFG_DEPTH = 256;
   localparam int CFG_WIDTH = 8;

   localparam logic [7:0] ADDR_CMD_LO    = 8'h04;
   localparam logic [7:0] ADDR_CMD_HI    = 8'h05;
   localparam logic [7:0] ADDR_STS_LO    = 8'h06;
   localparam logic [7:0] ADDR_STS_HI    = 8'h07;
   localparam logic [7:0] ADDR_REV       = 8'h08;
   localparam logic [7:0] ADDR_DMA_ALIAS = 8'h40;
   localparam logic [7:0] ADDR_PORT92    = 8'h4f;
   localparam logic [7:0] ADDR_IRQ_A     = 8'h60;
   localparam logic [7:0] ADDR_IRQ_C     = 8'h61;
   localparam logic [7:0] ADDR_IRQ_B     = 8'h62;
   localparam logic [7:0] ADDR_IRQ_D     = 8'h63;
   localparam logic [7:0] ADDR_TMR_LO    = 8'h80;
   localparam logic [7:0] ADDR_TMR_HI    = 8'h81;

   localparam logic [7:0]  IRQ_STEER_MIN_REV = 8'd3;
   localparam logic [7:0]  TMR_BASE_MASK     = 8'hfd;
   localparam logic [15:0] TMR_WIN_MASK      = 16'hfffc;
   localparam logic [7:0]  PORT75_BASE       = 8'hd3;
   localparam logic [15:0] PORT_STATUS_A     = 16'h0073;
   localparam logic [15:0] PORT_STATUS_B     = 16'h0075;
   localparam logic [4:0]  IRQ_DISABLED      = 5'd16;

   typedef struct packed {
      logic [2:0]  op;
      logic [2:0]  func;
      logic [15:0] addr;
      logic [15:0] wdata;
      logic        word_access;
   } req_type;

   typedef struct packed {
      logic [15:0] rdata;
      logic [4:0]  irq_route_a;
      logic [4:0]  irq_route_b;
      logic [4:0]  irq_route_c;
      logic [4:0]  irq_route_d;
      logic        dma_alias_on;
      logic        port92_on;
      logic        timer_window_on;
   } rsp_type;

   typedef struct packed {
      logic [7:0] revision_id;
      logic [1:0] pci_clock_sel;
   } csr_cfg_type;

   // power-on contents of the configuration space
   function automatic logic [7:0] reset_byte(input logic [7:0] a);
      logic [7:0] r;
      case (a)
         8'h00: r = 8'h86;
         8'h01: r = 8'h80;
         8'h02: r = 8'h84;
         8'h03: r = 8'h04;
         8'h04: r = 8'h07;
         8'h07: r = 8'h02;
         8'h40: r = 8'h20;
         8'h42: r = 8'h04;
         8'h44: r = 8'h20;
         8'h45: r = 8'h10;
         8'h46: r = 8'h0f;
         8'h48: r = 8'h01;
         8'h49: r = 8'h10;
         8'h4a: r = 8'h10;
         8'h4b: r = 8'h0f;
         8'h4c: r = 8'h56;
         8'h4d: r = 8'h40;
         8'h4e: r = 8'h07;
         8'h4f: r = 8'h4f;
         8'h60: r = 8'h80;
         8'h61: r = 8'h80;
         8'h62: r = 8'h80;
         8'h63: r = 8'h80;
         8'h80: r = 8'h78;
         8'ha0: r = 8'h08;
         8'ha8: r = 8'h0f;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic cfg_writable(input logic [7:0] a, input logic steer_ok);
      logic ro;
      ro = ((a >= 8'h0f) && (a < 8'h4c) && (a != ADDR_DMA_ALIAS))
         || ((a >= ADDR_IRQ_A) && (a <= ADDR_IRQ_D) && !steer_ok)
         || (a <= 8'h03) || ((a >= 8'h08) && (a <= 8'h0b)) || (a == 8'h0e);
      return !ro;
   endfunction

   // command/status bytes are forced, except bit 3 of the command low byte
   function automatic logic [7:0] cfg_store_value(input logic [7:0] a, input logic [7:0] v);
      logic [7:0] r;
      case (a)
         ADDR_CMD_LO: r = (v & 8'h08) | 8'h07;
         ADDR_CMD_HI: r = 8'h00;
         ADDR_STS_LO: r = 8'h00;
         ADDR_STS_HI: r = 8'h02;
         default:     r = v;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] irq_route(input logic [7:0] r);
      return r[7] ? IRQ_DISABLED : {1'b0, r[3:0]};
   endfunction

   function automatic logic in_window(input logic [15:0] port, input logic [15:0] base);
      return base[0] && ((port & TMR_WIN_MASK) == (base & TMR_WIN_MASK));
   endfunction

   function automatic logic [7:0] clk_add(input logic [1:0] sel);
      logic [7:0] r;
      case (sel)
         2'd0:    r = 8'h00;
         2'd1:    r = 8'h0c;
         2'd2:    r = 8'h08;
         2'd3:    r = 8'h04;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] io_byte(input logic [15:0] port, input logic [15:0] remain,
                                          input logic [15:0] base, input logic [1:0] sel);
      logic [7:0] r;
      if (in_window(port, base)) begin
         if (port[1]) r = 8'hff;
         else if (port[0]) r = remain[15:8];
         else r = remain[7:0];
      end else if (port == PORT_STATUS_B) begin
         r = PORT75_BASE | clk_add(sel);
      end else begin
         // port 0x73 and anything undecoded
         r = 8'hff;
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/pibt_ram.sv
module pibt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/pibt_csr.sv
module pibt_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output pibt_pkg::csr_cfg_type cfg
);

   logic [7:0] revision_ff;
   logic [1:0] clk_sel_ff;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         revision_ff <= 8'h00;
         clk_sel_ff  <= 2'd0;
      end else if (wr_en) begin
         case (paddr[2])
            pibt_pkg::CSR_REVISION: revision_ff <= pwdata[7:0];
            pibt_pkg::CSR_CLK_SEL:  clk_sel_ff  <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         pibt_pkg::CSR_REVISION: prdata = {24'h0, revision_ff};
         pibt_pkg::CSR_CLK_SEL:  prdata = {30'h0, clk_sel_ff};
         default:                prdata = 32'h0;
      endcase
   end

   assign cfg.revision_id   = revision_ff;
   assign cfg.pci_clock_sel = clk_sel_ff;

endmodule

>>> hw/rtl/pci_isa_bridge_config_and_us_timer.sv
// PCI-to-ISA bridge function-0 configuration space with a microsecond countdown.
// Each request (config read/write, io read/write, or a one-microsecond tick) gives
// exactly one response carrying read data plus the current IRQ routes, DMA alias
// flag, port-92 enable and timer window enable. One request is taken per clock
// unless the input stage is stalled behind a full output: it sits in the input
// register while the 256-byte config RAM is read (registered read, separate
// read and write ports), then its response lands in the output register, which
// drives rsp_valid; with the response side ready the sustained rate is one
// request per cycle. The output register lets the next request be taken while a
// response still waits. Config RAM contents come out of reset through per-byte
// valid bits, so there is no clearing pass and requests are taken straight after
// reset. Revision and PCI clock code are set through the APB port (0x0 and 0x4);
// the user must do so only while the block is idle; the block does not enforce it.
module pci_isa_bridge_config_and_us_timer (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  pibt_pkg::req_type req_data,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pibt_pkg::rsp_type rsp_data,
   // CSR (APB)
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int CFG_N = pibt_pkg::CFG_DEPTH;

   pibt_pkg::csr_cfg_type cfg;

   // input stage
   pibt_pkg::req_type item_ff;
   logic              item_vld_ff;
   // output stage
   pibt_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_vld_ff;

   logic adv;        // input stage moves to output stage this cycle
   logic item_hold;  // input stage stalled behind a full output
   logic load;

   // config RAM port and bypass
   logic [7:0]           rd_addr;
   logic [7:0]           ram_q;
   logic [CFG_N-1:0]     valid_ff;
   logic                 rd_vld_ff;
   logic                 byp_ff, byp_in;
   logic [7:0]           byp_data_ff;
   logic                 wr_en;
   logic [7:0]           wr_data;

   // shadow copies of the bytes that drive side outputs
   logic [7:0] sh40_ff, sh40_in;
   logic       port92_ff, port92_in;
   logic       dma_ff, dma_in;
   logic [7:0] irq_a_ff, irq_a_in, irq_b_ff, irq_b_in;
   logic [7:0] irq_c_ff, irq_c_in, irq_d_ff, irq_d_in;
   logic [7:0] tmr_lo_ff, tmr_lo_in, tmr_hi_ff, tmr_hi_in;

   // timer
   logic [15:0] reload_ff, reload_in;
   logic [15:0] remain_ff, remain_in;
   logic [15:0] tmr_base;
   logic [15:0] tmr_base_in;
   logic [15:0] tmp_reload;
   logic        tmp_hit;

   // request decode
   logic [7:0]  cfg_a;
   logic [7:0]  cfg_v;
   logic [7:0]  cfg_byte;
   logic        func0;
   logic [15:0] port0, port1;
   logic        win0, win1;
   logic [15:0] rdata;

   pibt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // ---------------------------------------------------------------- handshake
   assign adv       = item_vld_ff & (~rsp_vld_ff | rsp_ready);
   assign item_hold = item_vld_ff & ~adv;
   assign req_ready = ~item_vld_ff | adv;
   assign load      = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else if (load) begin
         item_vld_ff <= 1'b1;
      end else if (adv) begin
         item_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_data;
      end
   end

   // ---------------------------------------------------------------- config RAM
   // Read address follows whatever sits in the input stage next cycle; a stalled
   // request re-reads its own byte so the RAM output stays lined up with it.
   assign rd_addr = item_hold ? item_ff.addr[7:0] : req_data.addr[7:0];

   pibt_ram #(
      .WIDTH (pibt_pkg::CFG_WIDTH),
      .DEPTH (pibt_pkg::CFG_DEPTH)
   ) u_cfg_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cfg_a),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // write in flight to the byte being fetched: the RAM returns old data, so forward
   assign byp_in = wr_en & (rd_addr == cfg_a);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         byp_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[cfg_a] <= 1'b1;
         end
         byp_ff <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_vld_ff   <= valid_ff[rd_addr];
      byp_data_ff <= wr_data;
   end

   // ---------------------------------------------------------------- decode
   assign cfg_a    = item_ff.addr[7:0];
   assign cfg_v    = item_ff.wdata[7:0];
   assign func0    = (item_ff.func == 3'd0);
   assign tmr_base = {tmr_hi_ff, tmr_lo_ff & pibt_pkg::TMR_BASE_MASK};
   assign port0    = item_ff.addr;
   assign port1    = item_ff.addr + 16'd1;
   assign win0     = pibt_pkg::in_window(port0, tmr_base);
   assign win1     = pibt_pkg::in_window(port1, tmr_base);

   always_comb begin
      if (cfg_a == pibt_pkg::ADDR_REV) cfg_byte = cfg.revision_id;
      else if (byp_ff)                 cfg_byte = byp_data_ff;
      else if (rd_vld_ff)              cfg_byte = ram_q;
      else                             cfg_byte = pibt_pkg::reset_byte(cfg_a);
   end

   assign wr_data = pibt_pkg::cfg_store_value(cfg_a, cfg_v);
   assign wr_en   = adv & (item_ff.op == pibt_pkg::OP_CFG_WR) & func0
                  & pibt_pkg::cfg_writable(cfg_a,
                       cfg.revision_id >= pibt_pkg::IRQ_STEER_MIN_REV);

   // shadow updates from config writes
   always_comb begin
      sh40_in   = sh40_ff;
      port92_in = port92_ff;
      dma_in    = dma_ff;
      irq_a_in  = irq_a_ff;
      irq_b_in  = irq_b_ff;
      irq_c_in  = irq_c_ff;
      irq_d_in  = irq_d_ff;
      tmr_lo_in = tmr_lo_ff;
      tmr_hi_in = tmr_hi_ff;
      if (wr_en) begin
         case (cfg_a)
            pibt_pkg::ADDR_DMA_ALIAS: begin
               sh40_in = wr_data;
               // flag only follows an actual change of bit 6
               if (wr_data[6] != sh40_ff[6]) dma_in = wr_data[6];
            end
            pibt_pkg::ADDR_PORT92: port92_in = wr_data[6];
            pibt_pkg::ADDR_IRQ_A:  irq_a_in  = wr_data;
            pibt_pkg::ADDR_IRQ_B:  irq_b_in  = wr_data;
            pibt_pkg::ADDR_IRQ_C:  irq_c_in  = wr_data;
            pibt_pkg::ADDR_IRQ_D:  irq_d_in  = wr_data;
            pibt_pkg::ADDR_TMR_LO: tmr_lo_in = wr_data;
            pibt_pkg::ADDR_TMR_HI: tmr_hi_in = wr_data;
            default: ;
         endcase
      end
   end

   assign tmr_base_in = {tmr_hi_in, tmr_lo_in & pibt_pkg::TMR_BASE_MASK};

   // timer latch and countdown
   always_comb begin
      reload_in  = reload_ff;
      remain_in  = remain_ff;
      tmp_reload = reload_ff;
      tmp_hit    = 1'b0;
      if (adv) begin
         case (item_ff.op)
            pibt_pkg::OP_IO_WR: begin
               if (item_ff.word_access && win0) begin
                  // word inside the window: offset bit 1 picks counter or dead pair
                  if (!port0[1]) begin
                     tmp_reload = item_ff.wdata;
                     tmp_hit    = 1'b1;
                  end
               end else begin
                  // byte, or word split low byte first
                  if (win0 && !port0[1]) begin
                     if (port0[0]) tmp_reload[15:8] = item_ff.wdata[7:0];
                     else          tmp_reload[7:0]  = item_ff.wdata[7:0];
                     tmp_hit = 1'b1;
                  end
                  if (item_ff.word_access && win1 && !port1[1]) begin
                     if (port1[0]) tmp_reload[15:8] = item_ff.wdata[15:8];
                     else          tmp_reload[7:0]  = item_ff.wdata[15:8];
                     tmp_hit = 1'b1;
                  end
               end
               if (tmp_hit) begin
                  reload_in = tmp_reload;
                  remain_in = tmp_reload;
               end
            end
            pibt_pkg::OP_TICK: begin
               if (remain_ff != 16'd0) remain_in = remain_ff - 16'd1;
            end
            default: ;
         endcase
      end
   end

   // read data
   always_comb begin
      case (item_ff.op)
         pibt_pkg::OP_CFG_RD: rdata = func0 ? {8'h00, cfg_byte} : 16'h00ff;
         pibt_pkg::OP_IO_RD: begin
            if (item_ff.word_access && win0)
               rdata = port0[1] ? 16'hffff : remain_ff;
            else if (item_ff.word_access)
               rdata = {pibt_pkg::io_byte(port1, remain_ff, tmr_base, cfg.pci_clock_sel),
                        pibt_pkg::io_byte(port0, remain_ff, tmr_base, cfg.pci_clock_sel)};
            else
               rdata = {8'h00,
                        pibt_pkg::io_byte(port0, remain_ff, tmr_base, cfg.pci_clock_sel)};
         end
         default: rdata = 16'h0000;
      endcase
   end

   always_comb begin
      rsp_in.rdata           = rdata;
      rsp_in.irq_route_a     = pibt_pkg::irq_route(irq_a_in);
      rsp_in.irq_route_b     = pibt_pkg::irq_route(irq_b_in);
      rsp_in.irq_route_c     = pibt_pkg::irq_route(irq_c_in);
      rsp_in.irq_route_d     = pibt_pkg::irq_route(irq_d_in);
      rsp_in.dma_alias_on    = dma_in;
      rsp_in.port92_on       = port92_in;
      rsp_in.timer_window_on = tmr_base_in[0];
   end

   // ---------------------------------------------------------------- state
   always_ff @(posedge clock) begin
      if (reset) begin
         sh40_ff   <= pibt_pkg::reset_byte(pibt_pkg::ADDR_DMA_ALIAS);
         port92_ff <= 1'(pibt_pkg::reset_byte(pibt_pkg::ADDR_PORT92) >> 6);
         dma_ff    <= 1'b1;
         irq_a_ff  <= pibt_pkg::reset_byte(pibt_pkg::ADDR_IRQ_A);
         irq_b_ff  <= pibt_pkg::reset_byte(pibt_pkg::ADDR_IRQ_B);
         irq_c_ff  <= pibt_pkg::reset_byte(pibt_pkg::ADDR_IRQ_C);
         irq_d_ff  <= pibt_pkg::reset_byte(pibt_pkg::ADDR_IRQ_D);
         tmr_lo_ff <= pibt_pkg::reset_byte(pibt_pkg::ADDR_TMR_LO);
         tmr_hi_ff <= pibt_pkg::reset_byte(pibt_pkg::ADDR_TMR_HI);
         reload_ff <= 16'h0000;
         remain_ff <= 16'h0000;
      end else begin
         sh40_ff   <= sh40_in;
         port92_ff <= port92_in;
         dma_ff    <= dma_in;
         irq_a_ff  <= irq_a_in;
         irq_b_ff  <= irq_b_in;
         irq_c_ff  <= irq_c_in;
         irq_d_ff  <= irq_d_in;
         tmr_lo_ff <= tmr_lo_in;
         tmr_hi_ff <= tmr_hi_in;
         reload_ff <= reload_in;
         remain_ff <= remain_in;
      end
   end

   // ---------------------------------------------------------------- output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------- checks
   a_tick_decrements: assert property (@(posedge clock) disable iff (reset)
      (adv && item_ff.op == pibt_pkg::OP_TICK && remain_ff != 16'd0)
      |=> (remain_ff == $past(remain_ff) - 16'd1))
      else $error("countdown did not step on tick");

   a_bypass_from_write: assert property (@(posedge clock) disable iff (reset)
      byp_ff |-> $past(wr_en))
      else $error("config forward without a write");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      item_hold |-> !req_ready)
      else $error("request taken while input stage stalled");

   a_base_bit1_clear: assert property (@(posedge clock) disable iff (reset)
      tmr_base[1] == 1'b0)
      else $error("timer base bit 1 not masked");

endmodule
